// File: rtl/core/sli_pkg.sv
// Shared types and codes for the sorted list insert and read-out unit.
package sli_pkg;

    localparam int DATA_W = 32;

    // Action carried in s_tuser
    typedef enum logic [1:0] {
        ACT_INSERT   = 2'd0,
        ACT_READ_ASC = 2'd1,
        ACT_READ_DSC = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    // Status carried in m_tuser
    typedef enum logic [1:0] {
        STS_INSERTED = 2'd0,
        STS_FULL     = 2'd1,
        STS_ELEMENT  = 2'd2,
        STS_EMPTY    = 2'd3
    } status_t;

endpackage

// File: rtl/core/sli_ram.sv
// Generic single write port, single read port RAM with registered read data.
module sli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/sorted_list_insert_and_readout_unit.sv
// Sorted list store: ordered insert and full read-out over one RAM and one comparator.
//
// Keeps up to CAPACITY signed 32-bit values in ascending order in a RAM with
// registered read. The block takes one word at a time and drops s_tready while
// it works. An insert walks down from the tail, one RAM read and one compare per
// stored value, moving each value that is greater than or equal to the new value
// up one place and stopping at the first smaller one, then writes the new value
// into the free place and offers its status word (an empty list goes straight to
// the write). A refused insert (list full) or a read of an empty list goes
// straight to its status word without touching the RAM. A read-out emits each
// word through a RAM address step and then a registered data step, slower if
// m_tready is held low; the last word carries m_tlast. Action code 3 is accepted
// and dropped with no result. The RAM needs no clearing after reset.
module sorted_list_insert_and_readout_unit #(
    parameter int CAPACITY = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input words
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [sli_pkg::DATA_W-1:0] s_tdata,  // [31:0] value
    input  logic [1:0]                 s_tuser,  // [1:0] action
    // result words
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [sli_pkg::DATA_W-1:0] m_tdata,  // [31:0] element
    output logic [1:0]                 m_tuser,  // [1:0] status
    output logic                       m_tlast
);
    import sli_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_RD_ADDR,
        S_RD_DATA,
        S_RESULT
    } state_t;

    state_t              state_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       ptr_reg;
    logic [CW-1:0]       k_reg;
    logic                desc_reg;
    logic signed [31:0]  val_reg;
    status_t             res_reg;

    logic                m_tvalid_reg;
    logic [DATA_W-1:0]   m_tdata_reg;
    status_t             m_tuser_reg;
    logic                m_tlast_reg;

    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [DATA_W-1:0]   ram_wr_data;
    logic [AW-1:0]       ram_rd_addr;
    logic [DATA_W-1:0]   ram_rd_data;

    logic                in_accept;
    logic                out_free;
    logic                out_load;
    logic                ge;
    logic [CW-1:0]       rd_idx;
    logic                rd_last;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    // a new result word goes into the output register this cycle
    assign out_load  = out_free && (state_reg == S_RD_DATA || state_reg == S_RESULT);

    // shared comparator: stored value against the value being inserted
    assign ge = ($signed(ram_rd_data) >= val_reg);

    // read address: next value below the insert pointer, or the read-out slot
    always_comb begin
        if (state_reg == S_RD_ADDR || state_reg == S_RD_DATA) begin
            rd_idx = desc_reg ? (count_reg - CW'(1) - k_reg) : k_reg;
        end else begin
            rd_idx = ptr_reg - CW'(1);
        end
    end
    assign ram_rd_addr = rd_idx[AW-1:0];
    assign rd_last     = ((k_reg + CW'(1)) == count_reg);

    // RAM write: move a larger value up one place, or drop the new value in
    assign ram_wr_en   = (state_reg == S_INS_CMP && ge) || (state_reg == S_INS_PUT);
    assign ram_wr_addr = ptr_reg[AW-1:0];
    assign ram_wr_data = (state_reg == S_INS_PUT) ? val_reg : ram_rd_data;

    sli_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_accept) begin
                        val_reg <= s_tdata;
                        ptr_reg <= count_reg;
                        k_reg   <= '0;
                        case (s_tuser)
                            ACT_INSERT: begin
                                if (count_reg == CW'(CAPACITY)) begin
                                    res_reg   <= STS_FULL;
                                    state_reg <= S_RESULT;
                                end else if (count_reg == '0) begin
                                    state_reg <= S_INS_PUT;
                                end else begin
                                    state_reg <= S_INS_RD;
                                end
                            end
                            ACT_READ_ASC, ACT_READ_DSC: begin
                                desc_reg <= (s_tuser == ACT_READ_DSC);
                                if (count_reg == '0) begin
                                    res_reg   <= STS_EMPTY;
                                    state_reg <= S_RESULT;
                                end else begin
                                    state_reg <= S_RD_ADDR;
                                end
                            end
                            default: begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_INS_RD: begin
                    state_reg <= S_INS_CMP;
                end
                S_INS_CMP: begin
                    if (ge) begin
                        ptr_reg   <= ptr_reg - CW'(1);
                        state_reg <= (ptr_reg == CW'(1)) ? S_INS_PUT : S_INS_RD;
                    end else begin
                        state_reg <= S_INS_PUT;
                    end
                end
                S_INS_PUT: begin
                    count_reg <= count_reg + CW'(1);
                    res_reg   <= STS_INSERTED;
                    state_reg <= S_RESULT;
                end
                S_RD_ADDR: begin
                    state_reg <= S_RD_DATA;
                end
                S_RD_DATA: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= ram_rd_data;
                        m_tuser_reg  <= STS_ELEMENT;
                        m_tlast_reg  <= rd_last;
                        if (rd_last) begin
                            state_reg <= S_IDLE;
                        end else begin
                            k_reg     <= k_reg + CW'(1);
                            state_reg <= S_RD_ADDR;
                        end
                    end
                end
                S_RESULT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= '0;
                        m_tuser_reg  <= res_reg;
                        m_tlast_reg  <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
